[hdl/dtt_pkg.sv]
// ---------------------------------------------------------------------------
// dtt_pkg: shared types and constants of the deadline timer table
// Operation codes, status codes and the input and result item structs.
// ---------------------------------------------------------------------------
package dtt_pkg;

  localparam int SLOTS_DEFAULT = 16;
  localparam int MAX_RESULTS = 16;
  localparam logic [31:0] IDLE_WAIT_RESET = 32'd3000;
  localparam logic [47:0] TIME_MAX = 48'hFFFF_FFFF_FFFF;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_CANCEL = 3'd1;
  localparam logic [2:0] OP_REFRESH = 3'd2;
  localparam logic [2:0] OP_SET_INTERVAL = 3'd3;
  localparam logic [2:0] OP_COLLECT = 3'd4;
  localparam logic [2:0] OP_QUERY = 3'd5;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_INACTIVE = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_NONE = 2'd3;

  typedef struct packed {
    logic [2:0]  operation;
    logic [3:0]  timer_handle;
    logic [31:0] interval_ms;
    logic        recurring;
    logic        restart_now;
    logic [47:0] now_ms;
  } cmd_t;

  typedef struct packed {
    logic [3:0]  timer_handle_out;
    logic [1:0]  status;
    logic [47:0] wait_ms;
    logic        last;
  } result_t;

  function automatic logic [47:0] sat_add(input logic [47:0] base, input logic [31:0] add);
    logic [48:0] s;
    s = {1'b0, base} + {17'd0, add};
    return s[48] ? TIME_MAX : s[47:0];
  endfunction

endpackage

[hdl/dtt_slot_mem.sv]
// ---------------------------------------------------------------------------
// dtt_slot_mem: slot storage
// Synchronous memory of deadline, interval and recurring flag per slot,
// one write port and one registered read port.
// ---------------------------------------------------------------------------
module dtt_slot_mem #(
  parameter int SLOTS = dtt_pkg::SLOTS_DEFAULT,
  parameter int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [80:0]   wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [80:0]   rd_data
);

  logic [80:0] mem [SLOTS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[hdl/deadline_timer_table.sv]
// ---------------------------------------------------------------------------
// deadline_timer_table: table of software timers with deadline ordering
// Add and cancel answer directly; refresh and set_interval read the slot and
// write it back; query scans all slots once; collect scans once per due timer,
// up to MAX_RESULTS, and once more at the end. Each scan reads one slot per
// cycle from the slot memory. One item at a time; busy drops in the cycle of
// the last result. Synchronous reset clears all slots, idle_wait 3000.
// ---------------------------------------------------------------------------
module deadline_timer_table #(
  parameter int SLOTS = dtt_pkg::SLOTS_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  dtt_pkg::cmd_t    cmd,
  output logic             done,
  output dtt_pkg::result_t result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [31:0]      cfg_data
);

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam int NW = $clog2(dtt_pkg::MAX_RESULTS + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_FIX = 3'd2;
  localparam logic [2:0] S_EMIT = 3'd3;
  localparam logic [2:0] S_RESP = 3'd4;
  localparam logic [2:0] S_WAIT = 3'd5;

  logic [2:0]        state;
  logic [2:0]        state_next;
  dtt_pkg::cmd_t     c;
  dtt_pkg::cmd_t     c_next;
  logic [31:0]       idle_wait;
  logic [SLOTS-1:0]  active;
  logic [SLOTS-1:0]  active_next;
  logic [SLOTS-1:0]  done_set;
  logic [SLOTS-1:0]  done_set_next;
  logic [CW-1:0]     rd_cnt;
  logic [CW-1:0]     rd_cnt_next;
  logic              rd_vld;
  logic              rd_vld_next;
  logic [AW-1:0]     rd_slot;
  logic [AW-1:0]     rd_addr;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [80:0]       wr_data;
  logic [80:0]       rd_data;
  logic              any;
  logic              any_next;
  logic [47:0]       best_dl;
  logic [47:0]       best_dl_next;
  logic [AW-1:0]     best_slot;
  logic [AW-1:0]     best_slot_next;
  logic [AW-1:0]     pend_slot;
  logic [AW-1:0]     pend_slot_next;
  logic [NW-1:0]     n_out;
  logic [NW-1:0]     n_out_next;
  logic              emitted;
  logic              emitted_next;
  dtt_pkg::result_t  result_next;
  logic              done_next;
  logic [47:0]       rd_dl;
  logic [31:0]       rd_ivl;
  logic [47:0]       st;
  logic [AW-1:0]     tgt;
  logic [AW-1:0]     cmd_slot;
  logic [AW-1:0]     free_slot;

  assign rd_dl = rd_data[80:33];
  assign rd_ivl = rd_data[32:1];
  assign busy = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign tgt = AW'(c.timer_handle);
  assign cmd_slot = AW'(cmd.timer_handle);

  dtt_slot_mem #(.SLOTS(SLOTS), .AW(AW)) u_mem (
    .clk, .wr_en, .wr_addr, .wr_data, .rd_addr, .rd_data
  );

  always_comb begin
    state_next = state;
    c_next = c;
    active_next = active;
    done_set_next = done_set;
    rd_cnt_next = rd_cnt;
    rd_vld_next = 1'b0;
    any_next = any;
    best_dl_next = best_dl;
    best_slot_next = best_slot;
    pend_slot_next = pend_slot;
    n_out_next = n_out;
    emitted_next = emitted;
    result_next = result;
    done_next = 1'b0;
    wr_en = 1'b0;
    wr_addr = tgt;
    wr_data = '0;
    rd_addr = rd_cnt[AW-1:0];
    free_slot = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!active[i]) free_slot = AW'(i);
    end
    st = (rd_dl >= {16'd0, rd_ivl}) ? rd_dl - {16'd0, rd_ivl} : '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          c_next = cmd;
          rd_cnt_next = '0;
          any_next = 1'b0;
          n_out_next = '0;
          emitted_next = 1'b0;
          done_set_next = '0;
          result_next = '0;
          result_next.last = 1'b1;
          unique case (cmd.operation)
            dtt_pkg::OP_ADD: begin
              if (&active) begin
                result_next.status = dtt_pkg::ST_FULL;
              end else begin
                wr_en = 1'b1;
                wr_addr = free_slot;
                wr_data = {dtt_pkg::sat_add(cmd.now_ms, cmd.interval_ms), cmd.interval_ms,
                           cmd.recurring};
                active_next[free_slot] = 1'b1;
                result_next.timer_handle_out = 4'(free_slot);
              end
              state_next = S_RESP;
            end
            dtt_pkg::OP_CANCEL, dtt_pkg::OP_REFRESH, dtt_pkg::OP_SET_INTERVAL: begin
              result_next.timer_handle_out = cmd.timer_handle;
              if (32'(cmd.timer_handle) >= 32'(SLOTS) || !active[cmd_slot]) begin
                result_next.status = dtt_pkg::ST_INACTIVE;
                state_next = S_RESP;
              end else if (cmd.operation == dtt_pkg::OP_CANCEL) begin
                active_next[cmd_slot] = 1'b0;
                state_next = S_RESP;
              end else begin
                rd_cnt_next = CW'(cmd.timer_handle);
                state_next = S_WAIT;
              end
            end
            dtt_pkg::OP_COLLECT, dtt_pkg::OP_QUERY: begin
              state_next = S_SCAN;
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_WAIT: state_next = S_FIX;
      S_SCAN: begin
        if (rd_cnt < CW'(SLOTS)) begin
          rd_cnt_next = rd_cnt + CW'(1);
          rd_vld_next = 1'b1;
        end
        if (rd_vld && active[rd_slot] && !done_set[rd_slot] &&
            (c.operation == dtt_pkg::OP_QUERY || rd_dl <= c.now_ms) &&
            (!any || rd_dl < best_dl)) begin
          any_next = 1'b1;
          best_dl_next = rd_dl;
          best_slot_next = rd_slot;
        end
        if (rd_cnt == CW'(SLOTS) && !rd_vld) begin
          if (c.operation == dtt_pkg::OP_QUERY) begin
            result_next.wait_ms = !any ? {16'd0, idle_wait} :
                                  (best_dl <= c.now_ms) ? '0 : best_dl - c.now_ms;
            state_next = S_RESP;
          end else if (any && n_out < NW'(dtt_pkg::MAX_RESULTS)) begin
            rd_cnt_next = CW'(best_slot);
            state_next = S_WAIT;
          end else if (emitted) begin
            done_next = 1'b1;
            result_next.timer_handle_out = 4'(pend_slot);
            result_next.last = 1'b1;
            state_next = S_IDLE;
          end else begin
            result_next.status = dtt_pkg::ST_NONE;
            state_next = S_RESP;
          end
        end
      end
      S_FIX: begin
        if (c.operation == dtt_pkg::OP_REFRESH) begin
          wr_en = 1'b1;
          wr_data = {dtt_pkg::sat_add(c.now_ms, rd_ivl), rd_ivl, rd_data[0]};
          state_next = S_RESP;
        end else if (c.operation == dtt_pkg::OP_SET_INTERVAL) begin
          wr_en = 1'b1;
          wr_data = {dtt_pkg::sat_add(c.restart_now ? c.now_ms : st, c.interval_ms),
                     c.interval_ms, rd_data[0]};
          state_next = S_RESP;
        end else begin
          if (rd_data[0]) begin
            wr_en = 1'b1;
            wr_addr = best_slot;
            wr_data = {dtt_pkg::sat_add(c.now_ms, rd_ivl), rd_ivl, rd_data[0]};
          end else begin
            active_next[best_slot] = 1'b0;
          end
          done_set_next[best_slot] = 1'b1;
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (emitted) begin
          done_next = 1'b1;
          result_next.timer_handle_out = 4'(pend_slot);
          result_next.last = 1'b0;
        end
        pend_slot_next = best_slot;
        emitted_next = 1'b1;
        n_out_next = n_out + NW'(1);
        any_next = 1'b0;
        rd_cnt_next = '0;
        state_next = S_SCAN;
      end
      S_RESP: begin
        done_next = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      active <= '0;
      idle_wait <= dtt_pkg::IDLE_WAIT_RESET;
      done <= 1'b0;
      rd_vld <= 1'b0;
    end else begin
      state <= state_next;
      active <= active_next;
      if (cfg_valid) idle_wait <= cfg_data;
      done <= done_next;
      rd_vld <= rd_vld_next;
    end
  end

  always_ff @(posedge clk) begin
    c <= c_next;
    done_set <= done_set_next;
    rd_cnt <= rd_cnt_next;
    rd_slot <= rd_addr;
    any <= any_next;
    best_dl <= best_dl_next;
    best_slot <= best_slot_next;
    pend_slot <= pend_slot_next;
    n_out <= n_out_next;
    emitted <= emitted_next;
    result <= result_next;
  end

endmodule

[hdl/dtt_checker.sv]
// ---------------------------------------------------------------------------
// dtt_checker: port-level checks of the deadline timer table
// Watches the command, result and configuration ports.
// ---------------------------------------------------------------------------
module dtt_checker (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input dtt_pkg::cmd_t    cmd,
  input logic             done,
  input dtt_pkg::result_t result,
  input logic             cfg_ready
);

  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    start && !busy && cmd.operation <= dtt_pkg::OP_QUERY |=> busy)
    else $error("busy not raised");

  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done && !result.last |-> busy) else $error("partial result while idle");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    done && result.last && !(start && !busy) |=> !done) else $error("result after last");

  a_wait_only_ok: assert property (@(posedge clk) disable iff (rst)
    done && result.wait_ms != 48'd0 |-> result.status == dtt_pkg::ST_OK)
    else $error("wait with error status");

  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    !busy |-> cfg_ready) else $error("config blocked while idle");

endmodule

bind deadline_timer_table dtt_checker u_dtt_checker (
  .clk, .rst, .start, .busy, .cmd, .done, .result, .cfg_ready
);

[sim/deadline_timer_table_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// deadline_timer_table_checker: result predictor and comparator
// Watches the command, configuration and result channels of the timer table,
// keeps its own copy of the slots and the idle wait, and compares each
// strobed result against the oldest predicted one.
// ---------------------------------------------------------------------------
module deadline_timer_table_checker #(
  parameter int SLOTS = dtt_pkg::SLOTS_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             busy,
  input  dtt_pkg::cmd_t    cmd,
  input  logic             done,
  input  dtt_pkg::result_t result,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic [31:0]      cfg_data,
  output int               fail_count,
  output int               pending,
  output int               result_count
);

  logic [31:0]      idle_ms;
  logic             active   [SLOTS];
  logic [47:0]      deadline [SLOTS];
  logic [31:0]      period   [SLOTS];
  logic             reload   [SLOTS];
  dtt_pkg::result_t expected_q[$];

  assign pending = expected_q.size();

  function automatic logic [47:0] add_sat(logic [47:0] b, logic [31:0] a);
    logic [48:0] s;
    s = {1'b0, b} + {17'd0, a};
    return s[48] ? dtt_pkg::TIME_MAX : s[47:0];
  endfunction

  function automatic dtt_pkg::result_t mk(logic [3:0] h, logic [1:0] st, logic [47:0] w,
                                          logic l);
    dtt_pkg::result_t r;
    r.timer_handle_out = h;
    r.status = st;
    r.wait_ms = w;
    r.last = l;
    return r;
  endfunction

  function automatic void enqueue(input dtt_pkg::result_t r);
    expected_q.insert(expected_q.size(), r);
  endfunction

  task automatic predict_timer(input dtt_pkg::cmd_t c);
    int i, best, n;
    logic found;
    logic [47:0] lo, st;
    logic due [SLOTS];
    case (c.operation)
      dtt_pkg::OP_ADD: begin
        found = 0;
        for (i = 0; i < SLOTS && !found; i++) begin
          if (!active[i]) begin
            active[i] = 1;
            period[i] = c.interval_ms;
            reload[i] = c.recurring;
            deadline[i] = add_sat(c.now_ms, c.interval_ms);
            enqueue(mk(i[3:0], dtt_pkg::ST_OK, 0, 1));
            found = 1;
          end
        end
        if (!found) enqueue(mk(0, dtt_pkg::ST_FULL, 0, 1));
      end
      dtt_pkg::OP_CANCEL, dtt_pkg::OP_REFRESH, dtt_pkg::OP_SET_INTERVAL: begin
        if (c.timer_handle >= SLOTS || !active[c.timer_handle]) begin
          enqueue(mk(c.timer_handle, dtt_pkg::ST_INACTIVE, 0, 1));
        end else begin
          i = c.timer_handle;
          if (c.operation == dtt_pkg::OP_CANCEL) active[i] = 0;
          else if (c.operation == dtt_pkg::OP_REFRESH)
            deadline[i] = add_sat(c.now_ms, period[i]);
          else if (c.restart_now) begin
            period[i] = c.interval_ms;
            deadline[i] = add_sat(c.now_ms, c.interval_ms);
          end else begin
            st = (deadline[i] >= {16'd0, period[i]}) ? deadline[i] - period[i] : 0;
            period[i] = c.interval_ms;
            deadline[i] = add_sat(st, c.interval_ms);
          end
          enqueue(mk(c.timer_handle, dtt_pkg::ST_OK, 0, 1));
        end
      end
      dtt_pkg::OP_COLLECT: begin
        n = 0;
        for (i = 0; i < SLOTS; i++) due[i] = active[i] && deadline[i] <= c.now_ms;
        while (n < dtt_pkg::MAX_RESULTS) begin
          best = -1;
          for (i = 0; i < SLOTS; i++)
            if (due[i] && (best < 0 || deadline[i] < deadline[best])) best = i;
          if (best < 0) break;
          due[best] = 0;
          enqueue(mk(best[3:0], dtt_pkg::ST_OK, 0, 0));
          n++;
          if (reload[best]) deadline[best] = add_sat(c.now_ms, period[best]);
          else active[best] = 0;
        end
        if (n == 0) enqueue(mk(0, dtt_pkg::ST_NONE, 0, 1));
        else expected_q[$].last = 1;
      end
      dtt_pkg::OP_QUERY: begin
        found = 0;
        lo = 0;
        for (i = 0; i < SLOTS; i++)
          if (active[i] && (!found || deadline[i] < lo)) begin
            lo = deadline[i];
            found = 1;
          end
        if (!found) enqueue(mk(0, dtt_pkg::ST_OK, {16'd0, idle_ms}, 1));
        else if (lo <= c.now_ms) enqueue(mk(0, dtt_pkg::ST_OK, 0, 1));
        else enqueue(mk(0, dtt_pkg::ST_OK, lo - c.now_ms, 1));
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    dtt_pkg::result_t e;
    if (rst) begin
      idle_ms = dtt_pkg::IDLE_WAIT_RESET;
      for (int i = 0; i < SLOTS; i++) active[i] = 0;
      expected_q.delete();
      fail_count <= 0;
      result_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) idle_ms = cfg_data;
      if (done) begin
        result_count <= result_count + 1;
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result %p", $time, result);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_q.pop_front();
          if (result !== e) begin
            $display("%0t: mismatch expected %p actual %p", $time, e, result);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (start && !busy) predict_timer(cmd);
    end
  end
endmodule

[sim/deadline_timer_table_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// deadline_timer_table_tb: stimulus and verdict for the timer table
// Drives directed and random timer commands across several idle wait
// settings and sender idle phases; the checker predicts and compares.
// ---------------------------------------------------------------------------
module deadline_timer_table_tb;

  localparam int LIMIT = 20000;

  logic clk = 0, rst = 1, start = 0, cfg_valid = 0;
  logic busy, done, cfg_ready;
  logic [31:0] cfg_data = 0;
  dtt_pkg::cmd_t cmd = '0;
  dtt_pkg::result_t result;
  int fail_count, pending, result_count, idle_pct, stall, items;
  logic [47:0] clock_ms = 0;

  always #2 clk = ~clk;

  deadline_timer_table dut (.*);

  deadline_timer_table_checker chk (.*);

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) stall <= 0;
    else stall <= stall + 1;
    if (stall > LIMIT) begin
      $display("FAIL deadline_timer_table");
      $finish;
    end
  end

  task automatic issue(input logic [2:0] op, input logic [3:0] h, input logic [31:0] iv,
                       input logic rc, input logic fn, input logic [47:0] now);
    while ($urandom_range(99) < idle_pct) @(posedge clk);
    cmd <= '{op, h, iv, rc, fn, now};
    start <= 1;
    @(posedge clk);
    while (busy) @(posedge clk);
    start <= 0;
    @(posedge clk);
    items++;
  endtask

  task automatic quiesce();
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_idle(input logic [31:0] v);
    cfg_data <= v;
    cfg_valid <= 1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
  endtask

  task automatic random_cmd();
    logic [2:0] op;
    logic [31:0] iv;
    clock_ms = clock_ms + $urandom_range(40);
    case ($urandom_range(9))
      0, 1, 2: op = dtt_pkg::OP_ADD;
      3: op = dtt_pkg::OP_CANCEL;
      4: op = dtt_pkg::OP_REFRESH;
      5: op = dtt_pkg::OP_SET_INTERVAL;
      6, 7: op = dtt_pkg::OP_COLLECT;
      8: op = dtt_pkg::OP_QUERY;
      default: op = 3'($urandom_range(7));
    endcase
    iv = ($urandom_range(15) == 0) ? $urandom : $urandom_range(120);
    if ($urandom_range(30) == 0) clock_ms = 48'({$urandom, $urandom}) & dtt_pkg::TIME_MAX;
    issue(op, 4'($urandom), iv, 1'($urandom), 1'($urandom), clock_ms);
  endtask

  initial begin
    items = 0;
    idle_pct = 0;
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    issue(dtt_pkg::OP_QUERY, 0, 0, 0, 0, 0);
    issue(dtt_pkg::OP_COLLECT, 0, 0, 0, 0, 0);
    issue(dtt_pkg::OP_CANCEL, 15, 0, 0, 0, 5);
    issue(dtt_pkg::OP_REFRESH, 3, 0, 0, 0, 5);
    issue(dtt_pkg::OP_SET_INTERVAL, 0, 0, 0, 1, 5);
    for (int i = 0; i < 16; i++)
      issue(dtt_pkg::OP_ADD, 0, (i == 3) ? 32'hFFFF_FFFF : 32'(16 - i % 4), i[0], 0, 100);
    issue(dtt_pkg::OP_ADD, 0, 7, 0, 0, 100);
    issue(dtt_pkg::OP_SET_INTERVAL, 5, 50, 0, 0, 100);
    issue(dtt_pkg::OP_REFRESH, 2, 0, 0, 0, dtt_pkg::TIME_MAX);
    issue(dtt_pkg::OP_QUERY, 0, 0, 0, 0, 101);
    issue(dtt_pkg::OP_COLLECT, 0, 0, 0, 0, 200);
    issue(3'd6, 0, 0, 0, 0, 0);
    issue(3'd7, 4'hF, 32'hFFFF_FFFF, 1, 1, dtt_pkg::TIME_MAX);
    issue(dtt_pkg::OP_SET_INTERVAL, 3, 0, 0, 0, dtt_pkg::TIME_MAX);
    issue(dtt_pkg::OP_COLLECT, 0, 0, 0, 0, dtt_pkg::TIME_MAX);
    quiesce();
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: write_idle(0);
        1: write_idle(32'hFFFF_FFFF);
        2: write_idle($urandom);
        default: write_idle(3000);
      endcase
      idle_pct = (p == 1) ? 68 : (p == 2) ? 33 : 0;
      clock_ms = 0;
      for (int k = 0; k < 16; k++) issue(dtt_pkg::OP_CANCEL, k[3:0], 0, 0, 0, 0);
      issue(dtt_pkg::OP_QUERY, 0, 0, 0, 0, 0);
      for (int k = 0; k < 67; k++) random_cmd();
      quiesce();
    end
    $display("Covered %0d command items and %0d results over four idle wait settings.",
             items, result_count);
    if (fail_count == 0) $display("PASS deadline_timer_table");
    else $display("FAIL deadline_timer_table");
    $finish;
  end
endmodule
